/* design/apc_pkg.sv */
// apc_pkg: shared types and constants for the box/plane classifier.
// No dependencies; used by the interfaces, apc_product and the top level.

package apc_pkg;

    localparam int NORMAL_W  = 16;
    localparam int COORD_W   = 32;
    localparam int PROD_W    = NORMAL_W + COORD_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int FRAC_GAP  = 14;
    localparam int NUM_AXES  = 3;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        VERDICT_INTERSECT = 2'd0,
        VERDICT_POSITIVE  = 2'd1,
        VERDICT_NEGATIVE  = 2'd2
    } verdict_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MIN_Y = 3'd1,
        REG_BOX_MIN_Z = 3'd2,
        REG_BOX_MAX_X = 3'd3,
        REG_BOX_MAX_Y = 3'd4,
        REG_BOX_MAX_Z = 3'd5
    } reg_idx_t;

    typedef logic signed [NORMAL_W-1:0] normal_t;
    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

endpackage

/* design/apc_if.sv */
// apc_if: valid/ready channel interfaces for planes, verdicts and config writes.
// Depends on apc_pkg.

interface apc_plane_if;
    logic                   valid;
    logic                   ready;
    apc_pkg::normal_t       normal_x;
    apc_pkg::normal_t       normal_y;
    apc_pkg::normal_t       normal_z;
    apc_pkg::coord_t        plane_offset;
    logic                   last_plane;

    modport source (output valid, normal_x, normal_y, normal_z, plane_offset, last_plane,
                    input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, plane_offset, last_plane,
                    output ready);
endinterface

interface apc_result_if;
    logic                   valid;
    logic                   ready;
    apc_pkg::verdict_t      verdict;

    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

interface apc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [apc_pkg::CFG_IDX_W-1:0]   index;
    logic [apc_pkg::COORD_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/apc_product.sv */
// apc_product: per-axis corner selection and normal-by-bound products, registered.
// Depends on apc_pkg.

module apc_product
(
    input  logic              clk,
    input  logic              en,
    input  apc_pkg::normal_t  normal [apc_pkg::NUM_AXES],
    input  apc_pkg::coord_t   lo     [apc_pkg::NUM_AXES],
    input  apc_pkg::coord_t   hi     [apc_pkg::NUM_AXES],
    output apc_pkg::prod_t    pmin   [apc_pkg::NUM_AXES],
    output apc_pkg::prod_t    pmax   [apc_pkg::NUM_AXES]
);

    apc_pkg::prod_t pmin_reg  [apc_pkg::NUM_AXES];
    apc_pkg::prod_t pmax_reg  [apc_pkg::NUM_AXES];
    apc_pkg::prod_t pmin_next [apc_pkg::NUM_AXES];
    apc_pkg::prod_t pmax_next [apc_pkg::NUM_AXES];

    always_comb
    begin
        for (int a = 0; a < apc_pkg::NUM_AXES; a++)
        begin
            // positive component: near corner is the low bound
            if (!normal[a][apc_pkg::NORMAL_W-1] && (normal[a] != '0))
            begin
                pmin_next[a] = normal[a] * lo[a];
                pmax_next[a] = normal[a] * hi[a];
            end
            else
            begin
                pmin_next[a] = normal[a] * hi[a];
                pmax_next[a] = normal[a] * lo[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pmin_reg <= pmin_next;
            pmax_reg <= pmax_next;
        end
    end

    assign pmin = pmin_reg;
    assign pmax = pmax_reg;

endmodule

/* design/aabb_plane_classifier.sv */
// aabb_plane_classifier: top level; box config registers, plane pipeline, verdicts.
// Depends on apc_pkg, apc_if and apc_product.
// A verdict passes through the input register, the product register and the result register in turn.
// Throughput: one plane per cycle; the input stalls only while a verdict is held
// in a full result register that the sink does not take.
// Reset clears the box bounds to zero, empties the pipeline and starts a new batch.

module aabb_plane_classifier
(
    input  logic               clk,
    input  logic               rst_n,
    apc_cfg_if.sink            cfg,
    apc_plane_if.sink          plane,
    apc_result_if.source       result
);

    apc_pkg::coord_t   box_reg [apc_pkg::NUM_REGS];

    // stage 1: input register
    logic              s1_valid_reg;
    apc_pkg::normal_t  s1_normal_reg [apc_pkg::NUM_AXES];
    apc_pkg::coord_t   s1_offset_reg;
    logic              s1_last_reg;

    // stage 2: products
    logic              s2_valid_reg;
    apc_pkg::coord_t   s2_offset_reg;
    logic              s2_last_reg;
    apc_pkg::prod_t    pmin [apc_pkg::NUM_AXES];
    apc_pkg::prod_t    pmax [apc_pkg::NUM_AXES];

    // result register and batch state
    logic              out_valid_reg;
    logic              out_valid_next;
    apc_pkg::verdict_t out_verdict_reg;
    apc_pkg::verdict_t out_verdict_next;
    logic              settled_reg;
    logic              settled_next;

    apc_pkg::coord_t   lo [apc_pkg::NUM_AXES];
    apc_pkg::coord_t   hi [apc_pkg::NUM_AXES];
    apc_pkg::sum_t     dmin;
    apc_pkg::sum_t     dmax;
    apc_pkg::sum_t     thr;
    apc_pkg::verdict_t verdict;
    logic              emit;
    logic              out_en;
    logic              s2_adv;
    logic              s1_adv;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < apc_pkg::NUM_REGS; i++)
            begin
                box_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                apc_pkg::REG_BOX_MIN_X: box_reg[0] <= cfg.data;
                apc_pkg::REG_BOX_MIN_Y: box_reg[1] <= cfg.data;
                apc_pkg::REG_BOX_MIN_Z: box_reg[2] <= cfg.data;
                apc_pkg::REG_BOX_MAX_X: box_reg[3] <= cfg.data;
                apc_pkg::REG_BOX_MAX_Y: box_reg[4] <= cfg.data;
                apc_pkg::REG_BOX_MAX_Z: box_reg[5] <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int a = 0; a < apc_pkg::NUM_AXES; a++)
        begin
            lo[a] = box_reg[a];
            hi[a] = box_reg[a + apc_pkg::NUM_AXES];
        end
    end

    // handshake and stall chain
    assign out_en       = !out_valid_reg || result.ready;
    assign s2_adv       = !s2_valid_reg || !emit || out_en;
    assign s1_adv       = !s1_valid_reg || s2_adv;
    assign plane.ready  = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= plane.valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && plane.valid)
        begin
            s1_normal_reg[0] <= plane.normal_x;
            s1_normal_reg[1] <= plane.normal_y;
            s1_normal_reg[2] <= plane.normal_z;
            s1_offset_reg    <= plane.plane_offset;
            s1_last_reg      <= plane.last_plane;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_offset_reg <= s1_offset_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    apc_product u_product
    (
        .clk    (clk),
        .en     (s2_adv && s1_valid_reg),
        .normal (s1_normal_reg),
        .lo     (lo),
        .hi     (hi),
        .pmin   (pmin),
        .pmax   (pmax)
    );

    // sums and threshold, all exact at 30 fraction bits
    always_comb
    begin
        dmin = apc_pkg::SUM_W'(pmin[0]) + apc_pkg::SUM_W'(pmin[1])
             + apc_pkg::SUM_W'(pmin[2]);
        dmax = apc_pkg::SUM_W'(pmax[0]) + apc_pkg::SUM_W'(pmax[1])
             + apc_pkg::SUM_W'(pmax[2]);
        thr  = -(apc_pkg::SUM_W'(s2_offset_reg) <<< apc_pkg::FRAC_GAP);

        if (dmin >= thr)
        begin
            verdict = apc_pkg::VERDICT_POSITIVE;
        end
        else if (dmax <= thr)
        begin
            verdict = apc_pkg::VERDICT_NEGATIVE;
        end
        else
        begin
            verdict = apc_pkg::VERDICT_INTERSECT;
        end

        emit = s2_valid_reg && !settled_reg
            && ((verdict != apc_pkg::VERDICT_INTERSECT) || s2_last_reg);
    end

    // batch state and result register
    always_comb
    begin
        settled_next     = settled_reg;
        out_valid_next   = out_valid_reg;
        out_verdict_next = out_verdict_reg;

        if (s2_valid_reg && s2_adv)
        begin
            if (settled_reg)
            begin
                settled_next = !s2_last_reg;
            end
            else if (verdict != apc_pkg::VERDICT_INTERSECT)
            begin
                settled_next = !s2_last_reg;
            end
        end

        if (out_en)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                out_verdict_next = verdict;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settled_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            settled_reg   <= settled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_verdict_reg <= out_verdict_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.verdict = out_verdict_reg;

endmodule

/* tb/tb.sv */
// tb: self-checking bench for aabb_plane_classifier; random and directed plane batches
// against a configured box, verdicts predicted in a small scoreboard class.
// Depends on apc_pkg, apc_if and the design.

module tb;
    import apc_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_PLANES = 1700;
    localparam int MAX_REPORTS   = 10;

    localparam coord_t  COORD_MAX = 32'sh7FFF_FFFF;
    localparam coord_t  COORD_MIN = 32'sh8000_0000;
    localparam coord_t  ONE_Q16   = 32'sd65536;
    localparam normal_t NORM_MAX  = 16'sh7FFF;
    localparam normal_t NORM_MIN  = 16'sh8000;
    localparam normal_t ONE_Q14   = 16'sd16384;

    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

    typedef struct {
        normal_t nx;
        normal_t ny;
        normal_t nz;
        coord_t  offset;
        logic    last;
    } plane_item_t;

    class verdict_scoreboard;
        coord_t   box_lo[NUM_AXES];
        coord_t   box_hi[NUM_AXES];
        bit       settled;
        verdict_t verdicts_due[$];
        int       mismatches;
        int       evaluated;

        function new();
            int a;
            for (a = 0; a < NUM_AXES; a++)
            begin
                box_lo[a] = '0;
                box_hi[a] = '0;
            end
            settled    = 1'b0;
            mismatches = 0;
            evaluated  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
            if (idx < NUM_AXES)
                box_lo[idx] = data;
            else if (idx < NUM_REGS)
                box_hi[idx - NUM_AXES] = data;
        endfunction

        function void note_plane(plane_item_t p);
            longint   near_sum;
            longint   far_sum;
            longint   thr;
            longint   n;
            longint   lo;
            longint   hi;
            normal_t  nrm[NUM_AXES];
            verdict_t v;
            int       a;
            evaluated++;
            if (settled)
            begin
                if (p.last)
                    settled = 1'b0;
                return;
            end
            nrm[0] = p.nx;
            nrm[1] = p.ny;
            nrm[2] = p.nz;
            near_sum = 0;
            far_sum  = 0;
            for (a = 0; a < NUM_AXES; a++)
            begin
                n  = nrm[a];
                lo = box_lo[a];
                hi = box_hi[a];
                if (n > 0)
                begin
                    near_sum += n * lo;
                    far_sum  += n * hi;
                end
                else
                begin
                    near_sum += n * hi;
                    far_sum  += n * lo;
                end
            end
            thr = longint'(p.offset);
            thr = -(thr <<< FRAC_GAP);
            if (near_sum >= thr)
                v = VERDICT_POSITIVE;
            else if (far_sum <= thr)
                v = VERDICT_NEGATIVE;
            else
                v = VERDICT_INTERSECT;
            if (v != VERDICT_INTERSECT)
            begin
                verdicts_due.push_back(v);
                settled = !p.last;
            end
            else if (p.last)
                verdicts_due.push_back(VERDICT_INTERSECT);
        endfunction

        function void check_verdict(verdict_t got);
            verdict_t want;
            if (verdicts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected verdict %0d, none pending", got);
                return;
            end
            want = verdicts_due.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("verdict mismatch: expected %0d, got %0d", want, got);
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   steady_flow = 1'b0;
    int   idle_cycles = 0;

    verdict_scoreboard sb = new();

    apc_cfg_if    cfg_ch();
    apc_plane_if  plane_ch();
    apc_result_if result_ch();

    aabb_plane_classifier dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .plane  (plane_ch),
        .result (result_ch)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        if (steady_flow)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    function automatic coord_t clamp_coord(longint v);
        if (v > longint'(COORD_MAX))
            return COORD_MAX;
        if (v < longint'(COORD_MIN))
            return COORD_MIN;
        return coord_t'(v);
    endfunction

    // Callers enter every task right after a rising edge.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.write_reg(idx, data);
    endtask

    task automatic set_box(coord_t lx, coord_t ly, coord_t lz,
                           coord_t hx, coord_t hy, coord_t hz, bit spare);
        write_reg(REG_BOX_MIN_X, lx);
        write_reg(REG_BOX_MIN_Y, ly);
        write_reg(REG_BOX_MIN_Z, lz);
        write_reg(REG_BOX_MAX_X, hx);
        write_reg(REG_BOX_MAX_Y, hy);
        write_reg(REG_BOX_MAX_Z, hz);
        if (spare)
            write_reg($urandom_range(0, 1) ? SPARE_IDX_HI : SPARE_IDX_LO, $urandom);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_plane(plane_item_t p);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            plane_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        plane_ch.valid        <= 1'b1;
        plane_ch.normal_x     <= p.nx;
        plane_ch.normal_y     <= p.ny;
        plane_ch.normal_z     <= p.nz;
        plane_ch.plane_offset <= p.offset;
        plane_ch.last_plane   <= p.last;
        do
            @(posedge clk);
        while (plane_ch.ready !== 1'b1);
        sb.note_plane(p);
    endtask

    task automatic send_fields(normal_t nx, normal_t ny, normal_t nz, coord_t off, logic last);
        plane_item_t p;
        p.nx     = nx;
        p.ny     = ny;
        p.nz     = nz;
        p.offset = off;
        p.last   = last;
        send_plane(p);
    endtask

    task automatic drain();
        plane_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic plane_item_t make_plane(bit last);
        plane_item_t p;
        normal_t     n[NUM_AXES];
        longint      dot;
        longint      pt;
        longint      lo;
        longint      hi;
        int          a;
        for (a = 0; a < NUM_AXES; a++)
        begin
            case ($urandom_range(0, 7))
                0:       n[a] = '0;
                1:       n[a] = NORM_MAX;
                2:       n[a] = NORM_MIN;
                default: n[a] = normal_t'($urandom);
            endcase
        end
        if ($urandom_range(0, 9) < 7)
        begin
            // offset placed near a point of the box so all verdicts show up
            dot = 0;
            for (a = 0; a < NUM_AXES; a++)
            begin
                lo  = sb.box_lo[a];
                hi  = sb.box_hi[a];
                pt  = lo + ((hi - lo) * longint'($urandom_range(0, 256))) / 256;
                dot += n[a] * pt;
            end
            p.offset = clamp_coord(-(dot >>> FRAC_GAP)
                                   + (longint'($signed($urandom)) >>> $urandom_range(0, 31)));
        end
        else
            p.offset = coord_t'($urandom);
        p.nx   = n[0];
        p.ny   = n[1];
        p.nz   = n[2];
        p.last = last;
        return p;
    endfunction

    task automatic random_box();
        coord_t lo[NUM_AXES];
        coord_t hi[NUM_AXES];
        longint mid;
        longint half;
        int     a;
        int     style;
        style = $urandom_range(0, 9);
        for (a = 0; a < NUM_AXES; a++)
        begin
            if (style < 6)
            begin
                mid   = longint'($signed($urandom)) >>> $urandom_range(0, 12);
                half  = longint'($urandom) >> $urandom_range(2, 31);
                lo[a] = clamp_coord(mid - half);
                hi[a] = clamp_coord(mid + half);
            end
            else if (style < 8)
            begin
                lo[a] = $urandom;
                hi[a] = $urandom;
            end
            else if (style == 8)
            begin
                lo[a] = COORD_MIN;
                hi[a] = COORD_MAX;
            end
            else
            begin
                lo[a] = $urandom;
                hi[a] = lo[a];
            end
        end
        set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom_range(0, 3) == 0);
    endtask

    task automatic directed_part();
        // zero box after reset, a zero normal and then a nonzero normal
        send_fields('0, '0, '0, '0, 1'b1);
        send_fields(ONE_Q14, -ONE_Q14, '0, -32'sd1, 1'b1);
        drain();

        // unit box, spare register indexes must be ignored
        write_reg(SPARE_IDX_LO, 32'hFFFF_FFFF);
        write_reg(SPARE_IDX_HI, 32'hA5A5_5A5A);
        set_box(-ONE_Q16, -ONE_Q16, -ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16, 1'b0);
        send_fields(ONE_Q14, '0, '0, -32'sd131072, 1'b0);     // settles negative
        send_fields(NORM_MAX, NORM_MAX, NORM_MAX, '0, 1'b0);  // ignored
        send_fields(-ONE_Q14, '0, '0, 32'sd131072, 1'b1);     // ignored, ends batch
        send_fields(-ONE_Q14, '0, '0, 32'sd131072, 1'b1);     // positive on last plane
        send_fields('0, ONE_Q14, '0, '0, 1'b0);
        send_fields('0, '0, ONE_Q14, '0, 1'b1);               // intersecting
        send_fields(NORM_MIN, NORM_MAX, NORM_MIN, COORD_MIN, 1'b1);
        send_fields(NORM_MIN, NORM_MAX, NORM_MIN, COORD_MAX, 1'b1);
        send_fields(NORM_MAX, NORM_MAX, NORM_MAX, '0, 1'b1);
        drain();

        // widest box
        set_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_fields(NORM_MIN, NORM_MIN, NORM_MIN, COORD_MAX, 1'b1);
        send_fields(NORM_MAX, NORM_MAX, NORM_MAX, COORD_MIN, 1'b1);
        send_fields(16'sd1, '0, '0, '0, 1'b1);
        drain();

        // inverted box
        set_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_fields(16'sd1, 16'sd1, 16'sd1, '0, 1'b1);
        send_fields(-16'sd1, -16'sd1, -16'sd1, '0, 1'b1);
        send_fields('0, '0, '0, -32'sd1, 1'b1);
        send_fields(ONE_Q14, ONE_Q14, -ONE_Q14, COORD_MAX, 1'b1);
        drain();
    endtask

    task automatic random_part();
        int phase_end;
        int batch_len;
        int k;
        while (sb.evaluated < RANDOM_PLANES)
        begin
            random_box();
            steady_flow = ($urandom_range(0, 3) == 0);
            phase_end   = sb.evaluated + $urandom_range(60, 140);
            while (sb.evaluated < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                    batch_len = $urandom_range(9, 24);
                else
                    batch_len = $urandom_range(1, 6);
                for (k = 0; k < batch_len; k++)
                    send_plane(make_plane(k == batch_len - 1));
            end
            drain();
        end
    endtask

    // result sink with a random stall after each taken verdict
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        result_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                sb.check_verdict(result_ch.verdict);
                stall = pick_gap();
                if (stall != 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    result_ch.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((plane_ch.valid === 1'b1 && plane_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        plane_ch.valid        = 1'b0;
        plane_ch.normal_x     = '0;
        plane_ch.normal_y     = '0;
        plane_ch.normal_z     = '0;
        plane_ch.plane_offset = '0;
        plane_ch.last_plane   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_part();
        random_part();
        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
design/apc_pkg.sv
design/apc_if.sv
design/apc_product.sv
design/aabb_plane_classifier.sv
tb/tb.sv
